[rtl/sdfs_pkg.sv]
// Shared types, register indexes and reset values for the sprite direction frame sequencer.
// Used by every module of the block; depends on nothing else.
package sdfs_pkg;

    localparam int DIR_WIDTH_DEF  = 16;
    localparam int FRAME_BITS_DEF = 6;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int ELAPSED_W   = 16;
    localparam int COUNT_W     = 7;
    localparam int TICKS_W     = 32;
    localparam int CELL_W      = 10;
    localparam int TABLE_W     = 20;
    localparam int ROW_W       = 4;
    localparam int SLOT_W      = 3;
    localparam int RECT_LEFT_W = 16;
    localparam int RECT_TOP_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_WALK_FRAME_COUNT   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_FRAME_COUNT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WALK_FRAME_TICKS   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_FRAME_TICKS = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_WIDTH         = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_HEIGHT        = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WALK_ROW_TABLE     = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_ROW_TABLE   = 4'd7;

    localparam logic [COUNT_W-1:0] RST_FRAME_COUNT  = 7'd1;
    localparam logic [TICKS_W-1:0] RST_FRAME_TICKS  = 32'd1000;
    localparam logic [CELL_W-1:0]  RST_CELL_SIZE    = 10'd32;
    localparam logic [TABLE_W-1:0] RST_WALK_TABLE   = 20'h43210;
    localparam logic [TABLE_W-1:0] RST_ATTACK_TABLE = 20'h98765;

    localparam logic MODE_WALK   = 1'b0;
    localparam logic MODE_ATTACK = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_UP         = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_UP_RIGHT   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_RIGHT      = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_DOWN_RIGHT = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_DOWN       = 3'd4;

    typedef struct packed {
        logic [COUNT_W-1:0] walk_frame_count;
        logic [COUNT_W-1:0] attack_frame_count;
        logic [TICKS_W-1:0] walk_frame_ticks;
        logic [TICKS_W-1:0] attack_frame_ticks;
        logic [CELL_W-1:0]  cell_width;
        logic [CELL_W-1:0]  cell_height;
        logic [TABLE_W-1:0] walk_row_table;
        logic [TABLE_W-1:0] attack_row_table;
    } cfg_t;

    typedef struct packed {
        logic              nonzero;
        logic [SLOT_W-1:0] slot;
        logic              flip;
    } sector_t;

endpackage

[rtl/sdfs_dir_sort.sv]
// Direction sorter: magnitudes and the four sector products, registered, then the compare.
// Depends on sdfs_pkg for the sector type and slot codes.
module sdfs_dir_sort #(
    parameter int DIR_WIDTH = sdfs_pkg::DIR_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [DIR_WIDTH-1:0] dir_x,
    input  logic [DIR_WIDTH-1:0] dir_y,
    output sdfs_pkg::sector_t    sector
);
    import sdfs_pkg::*;

    localparam int SUM_W  = DIR_WIDTH + 2;
    localparam int SQ_W   = 2 * DIR_WIDTH;
    localparam int PROD_W = 2 * DIR_WIDTH + 2;

    logic [DIR_WIDTH-1:0] ax;
    logic [DIR_WIDTH-1:0] ay;
    logic                 x_neg;
    logic                 y_neg;
    logic [SUM_W-1:0]     sum_x;
    logic [SUM_W-1:0]     sum_y;

    logic [PROD_W-1:0] px_reg;
    logic [PROD_W-1:0] px_next;
    logic [PROD_W-1:0] py_reg;
    logic [PROD_W-1:0] py_next;
    logic [SQ_W-1:0]   sx_reg;
    logic [SQ_W-1:0]   sx_next;
    logic [SQ_W-1:0]   sy_reg;
    logic [SQ_W-1:0]   sy_next;
    logic              x_neg_reg;
    logic              y_neg_reg;
    logic              nonzero_reg;
    logic              nonzero_next;

    logic near_x;
    logic near_y;

    // The most negative input has a magnitude that still fits the unsigned width.
    assign x_neg = dir_x[DIR_WIDTH-1];
    assign y_neg = dir_y[DIR_WIDTH-1];
    assign ax    = x_neg ? (~dir_x + 1'b1) : dir_x;
    assign ay    = y_neg ? (~dir_y + 1'b1) : dir_y;

    assign sum_x = SUM_W'(ay) + {1'b0, ax, 1'b0};
    assign sum_y = SUM_W'(ax) + {1'b0, ay, 1'b0};

    assign px_next      = PROD_W'(ay) * PROD_W'(sum_x);
    assign py_next      = PROD_W'(ax) * PROD_W'(sum_y);
    assign sx_next      = SQ_W'(ax) * SQ_W'(ax);
    assign sy_next      = SQ_W'(ay) * SQ_W'(ay);
    assign nonzero_next = (|dir_x) | (|dir_y);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg      <= px_next;
            py_reg      <= py_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            x_neg_reg   <= x_neg;
            y_neg_reg   <= y_neg;
            nonzero_reg <= nonzero_next;
        end
    end

    assign near_x = px_reg < PROD_W'(sx_reg);
    assign near_y = py_reg < PROD_W'(sy_reg);

    always_comb
    begin
        sector.nonzero = nonzero_reg;
        if (near_x)
        begin
            sector.slot = SLOT_RIGHT;
            sector.flip = x_neg_reg;
        end
        else if (near_y)
        begin
            sector.slot = y_neg_reg ? SLOT_UP : SLOT_DOWN;
            sector.flip = 1'b0;
        end
        else
        begin
            sector.slot = y_neg_reg ? SLOT_UP_RIGHT : SLOT_DOWN_RIGHT;
            sector.flip = x_neg_reg;
        end
    end

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        load && dir_x == '0 && dir_y == '0 |=> !sector.nonzero)
        else $error("zero direction vector sorted as nonzero");

endmodule

[rtl/sdfs_anim_state.sv]
// Animation state: frame timer, frame number, sheet row and mirror flag, updated once per item.
// Depends on sdfs_pkg for the configuration and sector types.
module sdfs_anim_state #(
    parameter int FRAME_BITS = sdfs_pkg::FRAME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                commit,
    input  logic                                mode,
    input  logic [sdfs_pkg::ELAPSED_W-1:0]      elapsed,
    input  sdfs_pkg::sector_t                   sector,
    input  sdfs_pkg::cfg_t                      cfg,
    output logic [FRAME_BITS-1:0]               frame_number,
    output logic [sdfs_pkg::ROW_W-1:0]          sheet_row,
    output logic                                mirror_flag
);
    import sdfs_pkg::*;

    localparam int NEXT_W = FRAME_BITS + 1;
    localparam int CMP_W  = (NEXT_W > COUNT_W) ? NEXT_W : COUNT_W;

    logic [TICKS_W-1:0]    timer_reg;
    logic [TICKS_W-1:0]    timer_next;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic                  flip_reg;
    logic                  flip_next;

    logic [COUNT_W-1:0] count;
    logic [TICKS_W-1:0] ticks;
    logic [TABLE_W-1:0] table_sel;
    logic [TICKS_W:0]   timer_sum;
    logic [TICKS_W-1:0] timer_sat;
    logic               step;
    logic [CMP_W-1:0]   frame_inc;
    logic               wrap;
    logic [ROW_W-1:0]   slot_row;

    assign count     = (mode == MODE_ATTACK) ? cfg.attack_frame_count : cfg.walk_frame_count;
    assign ticks     = (mode == MODE_ATTACK) ? cfg.attack_frame_ticks : cfg.walk_frame_ticks;
    assign table_sel = (mode == MODE_ATTACK) ? cfg.attack_row_table : cfg.walk_row_table;

    // The timer saturates instead of wrapping.
    assign timer_sum = {1'b0, timer_reg} + (TICKS_W + 1)'(elapsed);
    assign timer_sat = timer_sum[TICKS_W] ? '1 : timer_sum[TICKS_W-1:0];
    assign step      = timer_sat >= ticks;

    assign frame_inc = CMP_W'(frame_reg) + CMP_W'(1);
    assign wrap      = (frame_inc >= CMP_W'(count)) || frame_inc[FRAME_BITS];

    always_comb
    begin
        unique case (sector.slot)
            SLOT_UP:         slot_row = table_sel[3:0];
            SLOT_UP_RIGHT:   slot_row = table_sel[7:4];
            SLOT_RIGHT:      slot_row = table_sel[11:8];
            SLOT_DOWN_RIGHT: slot_row = table_sel[15:12];
            SLOT_DOWN:       slot_row = table_sel[19:16];
            default:         slot_row = table_sel[3:0];
        endcase
    end

    always_comb
    begin
        timer_next = step ? '0 : timer_sat;
        frame_next = frame_reg;
        if (step)
        begin
            frame_next = wrap ? '0 : frame_inc[FRAME_BITS-1:0];
        end
        row_next  = sector.nonzero ? slot_row : row_reg;
        flip_next = sector.nonzero ? sector.flip : flip_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            frame_reg <= '0;
            row_reg   <= '0;
            flip_reg  <= 1'b0;
        end
        else if (commit)
        begin
            timer_reg <= timer_next;
            frame_reg <= frame_next;
            row_reg   <= row_next;
            flip_reg  <= flip_next;
        end
    end

    assign frame_number = frame_reg;
    assign sheet_row    = row_reg;
    assign mirror_flag  = flip_reg;

    a_hold_without_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(timer_reg) && $stable(frame_reg) && $stable(row_reg))
        else $error("animation state changed without an item");

    a_step_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        commit && step |=> timer_reg == '0)
        else $error("frame step did not clear the timer");

    a_zero_vector_keeps_row: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !sector.nonzero |=> $stable(row_reg) && $stable(flip_reg))
        else $error("zero vector changed the row or mirror flag");

endmodule

[rtl/sdfs_rect.sv]
// Result register: texture rectangle origin from frame and row times the cell size.
// Depends on sdfs_pkg for field widths.
module sdfs_rect #(
    parameter int FRAME_BITS = sdfs_pkg::FRAME_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic [FRAME_BITS-1:0]                 frame_number,
    input  logic [sdfs_pkg::ROW_W-1:0]            sheet_row,
    input  logic                                  mirror_flag,
    input  logic [sdfs_pkg::CELL_W-1:0]           cell_width,
    input  logic [sdfs_pkg::CELL_W-1:0]           cell_height,
    output logic [sdfs_pkg::RECT_LEFT_W-1:0]      rect_left,
    output logic [sdfs_pkg::RECT_TOP_W-1:0]       rect_top,
    output logic [FRAME_BITS-1:0]                 frame_index,
    output logic [sdfs_pkg::ROW_W-1:0]            row_index,
    output logic                                  mirrored
);
    import sdfs_pkg::*;

    localparam int LEFT_PROD_W = FRAME_BITS + CELL_W;
    localparam int TOP_PROD_W  = ROW_W + CELL_W;

    logic [LEFT_PROD_W-1:0] left_prod;
    logic [TOP_PROD_W-1:0]  top_prod;

    logic [RECT_LEFT_W-1:0] left_reg;
    logic [RECT_TOP_W-1:0]  top_reg;
    logic [FRAME_BITS-1:0]  frame_reg;
    logic [ROW_W-1:0]       row_reg;
    logic                   flip_reg;

    assign left_prod = LEFT_PROD_W'(frame_number) * LEFT_PROD_W'(cell_width);
    assign top_prod  = TOP_PROD_W'(sheet_row) * TOP_PROD_W'(cell_height);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= RECT_LEFT_W'(left_prod);
            top_reg   <= RECT_TOP_W'(top_prod);
            frame_reg <= frame_number;
            row_reg   <= sheet_row;
            flip_reg  <= mirror_flag;
        end
    end

    assign rect_left   = left_reg;
    assign rect_top    = top_reg;
    assign frame_index = frame_reg;
    assign row_index   = row_reg;
    assign mirrored    = flip_reg;

endmodule

[rtl/sprite_direction_frame_sequencer.sv]
// Top level of the sprite direction frame sequencer: handshakes, configuration registers, pipeline.
// Depends on sdfs_pkg, sdfs_dir_sort, sdfs_anim_state and sdfs_rect.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    mode, dir_x, dir_y, elapsed
//   out      out_valid / out_ready  rect_left, rect_top, frame_index, row_index, mirrored
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is accepted per cycle unless a stalled output has filled every stage. The stages
// are input register, sector products, state update, rectangle product. The state update
// stage sets the rate: timer add, saturate and compare are combinational within that stage.
// Reset restores the register defaults and clears the state; the block is ready at once. A
// stalled output holds each stage that is full; empty stages behind it keep filling.
module sprite_direction_frame_sequencer #(
    parameter int DIR_WIDTH  = sdfs_pkg::DIR_WIDTH_DEF,
    parameter int FRAME_BITS = sdfs_pkg::FRAME_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [DIR_WIDTH-1:0]                  dir_x,
    input  logic [DIR_WIDTH-1:0]                  dir_y,
    input  logic [sdfs_pkg::ELAPSED_W-1:0]        elapsed,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sdfs_pkg::RECT_LEFT_W-1:0]      rect_left,
    output logic [sdfs_pkg::RECT_TOP_W-1:0]       rect_top,
    output logic [FRAME_BITS-1:0]                 frame_index,
    output logic [sdfs_pkg::ROW_W-1:0]            row_index,
    output logic                                  mirrored,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sdfs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sdfs_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sdfs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 v4_reg;
    logic                 mode1_reg;
    logic [DIR_WIDTH-1:0] dir_x1_reg;
    logic [DIR_WIDTH-1:0] dir_y1_reg;
    logic [ELAPSED_W-1:0] elapsed1_reg;
    logic                 mode2_reg;
    logic [ELAPSED_W-1:0] elapsed2_reg;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic accept;
    logic move12;
    logic move23;
    logic move34;
    logic deliver;

    sector_t               sector;
    logic [FRAME_BITS-1:0] frame_number;
    logic [ROW_W-1:0]      sheet_row;
    logic                  mirror_flag;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WALK_FRAME_COUNT:   cfg_next.walk_frame_count   = cfg_data[COUNT_W-1:0];
                REG_ATTACK_FRAME_COUNT: cfg_next.attack_frame_count = cfg_data[COUNT_W-1:0];
                REG_WALK_FRAME_TICKS:   cfg_next.walk_frame_ticks   = cfg_data[TICKS_W-1:0];
                REG_ATTACK_FRAME_TICKS: cfg_next.attack_frame_ticks = cfg_data[TICKS_W-1:0];
                REG_CELL_WIDTH:         cfg_next.cell_width         = cfg_data[CELL_W-1:0];
                REG_CELL_HEIGHT:        cfg_next.cell_height        = cfg_data[CELL_W-1:0];
                REG_WALK_ROW_TABLE:     cfg_next.walk_row_table     = cfg_data[TABLE_W-1:0];
                REG_ATTACK_ROW_TABLE:   cfg_next.attack_row_table   = cfg_data[TABLE_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.walk_frame_count   <= RST_FRAME_COUNT;
            cfg_reg.attack_frame_count <= RST_FRAME_COUNT;
            cfg_reg.walk_frame_ticks   <= RST_FRAME_TICKS;
            cfg_reg.attack_frame_ticks <= RST_FRAME_TICKS;
            cfg_reg.cell_width         <= RST_CELL_SIZE;
            cfg_reg.cell_height        <= RST_CELL_SIZE;
            cfg_reg.walk_row_table     <= RST_WALK_TABLE;
            cfg_reg.attack_row_table   <= RST_ATTACK_TABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Each stage takes a new item when it is empty or its item moves on.
    assign rdy4    = !v4_reg || out_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign accept  = in_valid && rdy1;
    assign move12  = v1_reg && rdy2;
    assign move23  = v2_reg && rdy3;
    assign move34  = v3_reg && rdy4;
    assign deliver = v4_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept ? 1'b1 : (move12 ? 1'b0 : v1_reg);
            v2_reg <= move12 ? 1'b1 : (move23 ? 1'b0 : v2_reg);
            v3_reg <= move23 ? 1'b1 : (move34 ? 1'b0 : v3_reg);
            v4_reg <= move34 ? 1'b1 : (deliver ? 1'b0 : v4_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode1_reg    <= mode;
            dir_x1_reg   <= dir_x;
            dir_y1_reg   <= dir_y;
            elapsed1_reg <= elapsed;
        end
        if (move12)
        begin
            mode2_reg    <= mode1_reg;
            elapsed2_reg <= elapsed1_reg;
        end
    end

    sdfs_dir_sort #(
        .DIR_WIDTH (DIR_WIDTH)
    ) u_dir_sort (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (move12),
        .dir_x  (dir_x1_reg),
        .dir_y  (dir_y1_reg),
        .sector (sector)
    );

    sdfs_anim_state #(
        .FRAME_BITS (FRAME_BITS)
    ) u_anim_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (move23),
        .mode         (mode2_reg),
        .elapsed      (elapsed2_reg),
        .sector       (sector),
        .cfg          (cfg_reg),
        .frame_number (frame_number),
        .sheet_row    (sheet_row),
        .mirror_flag  (mirror_flag)
    );

    sdfs_rect #(
        .FRAME_BITS (FRAME_BITS)
    ) u_rect (
        .clk          (clk),
        .load         (move34),
        .frame_number (frame_number),
        .sheet_row    (sheet_row),
        .mirror_flag  (mirror_flag),
        .cell_width   (cfg_reg.cell_width),
        .cell_height  (cfg_reg.cell_height),
        .rect_left    (rect_left),
        .rect_top     (rect_top),
        .frame_index  (frame_index),
        .row_index    (row_index),
        .mirrored     (mirrored)
    );

    assign out_valid = v4_reg;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted item did not reach the input register");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> v1_reg && v2_reg && v3_reg && v4_reg && !out_ready)
        else $error("input stalled while the pipeline had room");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rect_left) && $stable(rect_top)
            && $stable(frame_index) && $stable(row_index) && $stable(mirrored))
        else $error("waiting result changed before it was taken");

endmodule
